### src/frsm_pkg.sv
// Shared constants and types for the Fibonacci range-sum block.
`default_nettype none

package frsm_pkg;

    // Field widths fixed by the interface
    localparam int IDX_W = 32;
    localparam int RES_W = 30;

    // Prime modulus and Barrett constant floor(2^60 / P)
    localparam logic [RES_W-1:0] P      = 30'd1000000007;
    localparam logic [30:0]      MU     = 31'd1152921496;
    localparam logic [31:0]      TWO_P  = 32'd2000000014;

    // Product slot tags: square terms first, then accumulator terms
    typedef enum logic [2:0] {
        TAG_AA = 3'd0,  // a*a
        TAG_BB = 3'd1,  // b*b
        TAG_BS = 3'd2,  // b*(2a-b)
        TAG_XA = 3'd3,  // x*a
        TAG_YB = 3'd4,  // y*b
        TAG_XB = 3'd5,  // x*b
        TAG_YD = 3'd6   // y*(a-b)
    } t_tag;

    typedef struct packed {
        logic start;      // transfer accepted: load high exponent
        logic next_term;  // save high term, load low exponent
        logic prep;       // derive a-b and 2a-b
        logic issue;      // send one product to the multiplier
        t_tag tag;
        logic update;     // fold products back into base/acc
        logic write_out;  // load result register
    } t_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_bit;
        logic mul_busy;
    } t_stat;

endpackage

`default_nettype wire

### src/frsm_modmul.sv
// Pipelined 30x30 modular multiplier with Barrett reduction, five stages.
`default_nettype none

module frsm_modmul (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire frsm_pkg::t_tag           i_tag,
    input  wire logic [frsm_pkg::RES_W-1:0] i_a,
    input  wire logic [frsm_pkg::RES_W-1:0] i_b,
    output logic                          o_valid,
    output frsm_pkg::t_tag                o_tag,
    output logic [frsm_pkg::RES_W-1:0]    o_value,
    output logic                          o_busy
);
    import frsm_pkg::*;

    logic [59:0] w_prod;
    logic [61:0] w_q_full;
    logic [60:0] w_qp;

    logic [59:0] r_s1_prod;
    logic [30:0] r_s2_q;
    logic [31:0] r_s2_lo;
    logic [31:0] r_s3_qp;
    logic [31:0] r_s3_lo;
    logic [31:0] r_s4_r;
    logic [RES_W-1:0] r_s5_val;

    logic [4:0] r_vld;
    t_tag       r_tag [5];

    assign w_prod   = i_a * i_b;
    assign w_q_full = r_s1_prod[59:29] * MU;
    assign w_qp     = r_s2_q * P;

    always_ff @(posedge i_clk) begin
        r_s1_prod <= w_prod;
        r_s2_q    <= w_q_full[61:31];
        r_s2_lo   <= r_s1_prod[31:0];
        r_s3_qp   <= w_qp[31:0];
        r_s3_lo   <= r_s2_lo;
        // remainder is below 3P, so 32 bits hold it exactly
        r_s4_r    <= r_s3_lo - r_s3_qp;
        if (r_s4_r >= TWO_P) begin
            r_s5_val <= RES_W'(r_s4_r - TWO_P);
        end else if (r_s4_r >= {2'b00, P}) begin
            r_s5_val <= RES_W'(r_s4_r - {2'b00, P});
        end else begin
            r_s5_val <= RES_W'(r_s4_r);
        end
        r_tag[0] <= i_tag;
        for (int k = 1; k < 5; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    assign o_valid = r_vld[4];
    assign o_tag   = r_tag[4];
    assign o_value = r_s5_val;
    assign o_busy  = |r_vld;

    a_val_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_s5_val < P))
        else $error("modmul result not reduced");

endmodule

`default_nettype wire

### src/frsm_datapath.sv
// Datapath: exponent, base and accumulator matrices, product slots, result register.
`default_nettype none

module frsm_datapath #(
    parameter int INDEX_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire frsm_pkg::t_cmd             i_cmd,
    output frsm_pkg::t_stat                 o_stat,
    input  wire logic [frsm_pkg::IDX_W-1:0] i_range_start,
    input  wire logic [frsm_pkg::IDX_W-1:0] i_range_end,
    output logic [frsm_pkg::RES_W-1:0]      o_range_sum
);
    import frsm_pkg::*;

    localparam int EXP_W = INDEX_BITS + 2;

    function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b);
        logic [RES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P}) begin
            s = s - {1'b0, P};
        end
        return s[RES_W-1:0];
    endfunction

    function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b);
        logic [RES_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, P} - {1'b0, b};
        end
        return s[RES_W-1:0];
    endfunction

    logic [EXP_W-1:0] w_n_idx;
    logic [EXP_W-1:0] w_m_idx;

    generate
        if (INDEX_BITS >= IDX_W) begin : g_wide
            assign w_n_idx = EXP_W'(i_range_start);
            assign w_m_idx = EXP_W'(i_range_end);
        end else begin : g_narrow
            assign w_n_idx = EXP_W'(i_range_start[INDEX_BITS-1:0]);
            assign w_m_idx = EXP_W'(i_range_end[INDEX_BITS-1:0]);
        end
    endgenerate

    // base = [[a,b],[b,a-b]], acc = [[x,y],[y,x-y]]
    logic [RES_W-1:0] r_a, r_b, r_x, r_y, r_bd, r_bs;
    logic [RES_W-1:0] r_hi, r_out;
    logic [EXP_W-1:0] r_exp, r_pend;
    logic [RES_W-1:0] r_slot [7];

    logic [RES_W-1:0] w_op_a, w_op_b;
    logic             w_mul_valid;
    t_tag             w_mul_tag;
    logic [RES_W-1:0] w_mul_value;
    logic             w_mul_busy;

    always_comb begin
        unique case (i_cmd.tag)
            TAG_AA:  begin w_op_a = r_a; w_op_b = r_a;  end
            TAG_BB:  begin w_op_a = r_b; w_op_b = r_b;  end
            TAG_BS:  begin w_op_a = r_b; w_op_b = r_bs; end
            TAG_XA:  begin w_op_a = r_x; w_op_b = r_a;  end
            TAG_YB:  begin w_op_a = r_y; w_op_b = r_b;  end
            TAG_XB:  begin w_op_a = r_x; w_op_b = r_b;  end
            TAG_YD:  begin w_op_a = r_y; w_op_b = r_bd; end
            default: begin w_op_a = '0;  w_op_b = '0;   end
        endcase
    end

    frsm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.issue),
        .i_tag   (i_cmd.tag),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_valid (w_mul_valid),
        .o_tag   (w_mul_tag),
        .o_value (w_mul_value),
        .o_busy  (w_mul_busy)
    );

    always_ff @(posedge i_clk) begin
        if (w_mul_valid) begin
            r_slot[w_mul_tag] <= w_mul_value;
        end
        if (i_cmd.start || i_cmd.next_term) begin
            r_a <= RES_W'(1);
            r_b <= RES_W'(1);
            r_x <= RES_W'(1);
            r_y <= '0;
        end
        if (i_cmd.start) begin
            r_exp  <= w_m_idx + EXP_W'(2);
            r_pend <= w_n_idx + EXP_W'(1);
        end
        if (i_cmd.next_term) begin
            r_hi  <= r_y;
            r_exp <= r_pend;
        end
        if (i_cmd.prep) begin
            r_bd <= mod_sub(r_a, r_b);
            r_bs <= mod_add(mod_sub(r_a, r_b), r_a);
        end
        if (i_cmd.update) begin
            r_a <= mod_add(r_slot[TAG_AA], r_slot[TAG_BB]);
            r_b <= r_slot[TAG_BS];
            if (r_exp[0]) begin
                r_x <= mod_add(r_slot[TAG_XA], r_slot[TAG_YB]);
                r_y <= mod_add(r_slot[TAG_XB], r_slot[TAG_YD]);
            end
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.write_out) begin
            r_out <= mod_sub(r_hi, r_y);
        end
    end

    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_bit  = r_exp[0];
    assign o_stat.mul_busy = w_mul_busy;
    assign o_range_sum     = r_out;

endmodule

`default_nettype wire

### src/frsm_ctrl.sv
// Controller: sequences exponent bits, product issue and result transfer.
`default_nettype none

module frsm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire frsm_pkg::t_stat i_stat,
    output frsm_pkg::t_cmd       o_cmd
);
    import frsm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_ISSUE  = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_tag   r_tag, n_tag;
    logic   r_phase, n_phase;      // 0: high term, 1: low term
    logic   r_out_valid, n_out_valid;
    t_tag   w_last;
    t_cmd   w_cmd;

    assign w_last = i_stat.exp_bit ? TAG_YD : TAG_BS;

    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.start = 1'b1;
                    n_phase     = 1'b0;
                    n_state     = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_stat.exp_zero) begin
                    if (!r_phase) begin
                        w_cmd.next_term = 1'b1;
                        n_phase         = 1'b1;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    w_cmd.prep = 1'b1;
                    n_tag      = TAG_AA;
                    n_state    = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                w_cmd.issue = 1'b1;
                w_cmd.tag   = r_tag;
                if (r_tag == w_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_tag = t_tag'(r_tag + 3'd1);
                end
            end
            ST_DRAIN: begin
                if (!i_stat.mul_busy) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                w_cmd.update = 1'b1;
                n_state      = ST_PREP;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.write_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tag       <= TAG_AA;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tag       <= n_tag;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_update_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> !i_stat.mul_busy)
        else $error("update before all products landed");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && r_out_valid && !i_out_ready |=> (r_state == ST_DONE))
        else $error("pending result overwritten");

    a_square_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) && !i_stat.exp_bit |->
            (r_tag == TAG_AA) || (r_tag == TAG_BB) || (r_tag == TAG_BS))
        else $error("accumulator product issued for clear exponent bit");

endmodule

`default_nettype wire

### src/fibonacci_range_sum_mod_unit.sv
// Top level of the Fibonacci range-sum modulo 1000000007 unit.
// Each item computes two terms, with exponents end+2 and then start+1.
//   Each exponent bit takes a prep step, the issue of 3 products (7 when
//   the bit is set), a drain of the multiplier and an update step.
// One item at a time: the controller accepts a transfer only when idle;
//   all products share the one five-stage modular multiplier.
// Reset (synchronous, active low) clears the controller and pipeline valids only.
`default_nettype none

module fibonacci_range_sum_mod_unit #(
    parameter int INDEX_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [frsm_pkg::IDX_W-1:0] i_range_start,
    input  wire logic [frsm_pkg::IDX_W-1:0] i_range_end,
    // output channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [frsm_pkg::RES_W-1:0]      o_range_sum
);
    import frsm_pkg::*;

    // The sum F(N)..F(M) is F(M+2) - F(N+1) mod P. Each term comes from
    // binary exponentiation of [[1,1],[1,0]], LSB first. Powers of that
    // matrix are symmetric with d = a - b, so a matrix is kept as two values:
    //   square:   a' = a^2 + b^2,  b' = b*(2a-b)           (3 products)
    //   multiply: x' = x*a + y*b,  y' = x*b + y*(a-b)      (4 products)
    // Products stream through one pipelined multiplier and land in tagged
    // slots; the controller waits for the drain before folding them back.
    // Exponent scanning stops once the remaining exponent is zero, since
    // further bits would leave the accumulator unchanged.

    t_cmd  w_cmd;
    t_stat w_stat;

    frsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Result register is separate from the work state, so a new transfer
    // can be accepted while the previous result still waits downstream.
    frsm_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_range_sum   (o_range_sum)
    );

endmodule

`default_nettype wire
